@@ hw/rtl/tpcm_pkg.sv @@
package tpcm_pkg;

	// Number of pixel levels that span the full palette.
	localparam int LEVELS     = 256;
	localparam int LEVEL_W    = 8;
	localparam int CH_W       = 8;
	localparam int FULL_SCALE = 255;

	localparam int NUM_PAL = 7;
	localparam int PAL_W   = 3;
	localparam int Q_W     = 3;
	localparam int SEG_W   = 3;

	// Stop table: one entry per palette and segment, addressed as {palette, segment}.
	localparam int TABLE_DEPTH = NUM_PAL << Q_W;
	localparam int TADDR_W     = $clog2(TABLE_DEPTH);
	localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);

	// Segment position arithmetic.
	localparam int K_W   = $clog2(LEVELS);
	localparam int M_W   = $clog2(LEVELS + 1);
	localparam int POS_W = LEVEL_W + SEG_W;
	localparam int LIM_W = $clog2(4 * LEVELS + 1);
	localparam int CMP_W = (POS_W > LIM_W) ? POS_W : LIM_W;

	// Exact division by LEVELS through a reciprocal: x < 2**X_W always holds.
	localparam int X_W     = $clog2(FULL_SCALE * LEVELS + LEVELS / 2 + 1);
	localparam int LOG_L   = $clog2(LEVELS);
	localparam int DIV_SH  = X_W + LOG_L;
	localparam int RECIP_W = X_W + 1;
	localparam int PROD_W  = X_W + RECIP_W;
	localparam longint unsigned RECIP_L = ((64'd1 << DIV_SH) + LEVELS - 1) / LEVELS;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

	typedef enum logic [PAL_W-1:0] {
		PAL_BYR,
		PAL_BRY,
		PAL_BGYR,
		PAL_WHITE_HOT,
		PAL_BLACK_HOT,
		PAL_BK_BYRW,
		PAL_BK_BRYW
	} palette_t;

	// Stop colors: bit 2 red, bit 1 green, bit 0 blue.
	typedef logic [2:0] rgb_t;

	localparam rgb_t RGB_BLACK  = 3'b000;
	localparam rgb_t RGB_BLUE   = 3'b001;
	localparam rgb_t RGB_GREEN  = 3'b010;
	localparam rgb_t RGB_RED    = 3'b100;
	localparam rgb_t RGB_YELLOW = 3'b110;
	localparam rgb_t RGB_WHITE  = 3'b111;

	typedef struct packed {
		rgb_t lo;
		rgb_t hi;
	} stop_pair_t;

	// Number of segments, one less than the number of stops.
	function automatic logic [SEG_W-1:0] seg_count(input palette_t pal);
		logic [SEG_W-1:0] n;
		case (pal)
			PAL_BYR:       n = SEG_W'(2);
			PAL_BRY:       n = SEG_W'(2);
			PAL_BGYR:      n = SEG_W'(3);
			PAL_WHITE_HOT: n = SEG_W'(1);
			PAL_BLACK_HOT: n = SEG_W'(1);
			PAL_BK_BYRW:   n = SEG_W'(4);
			PAL_BK_BRYW:   n = SEG_W'(4);
			default:       n = SEG_W'(2);
		endcase
		return n;
	endfunction

	function automatic rgb_t stop_rgb(input palette_t pal, input logic [Q_W-1:0] q);
		rgb_t s0, s1, s2, s3, s4, c;
		s0 = RGB_BLACK;
		s1 = RGB_BLACK;
		s2 = RGB_BLACK;
		s3 = RGB_BLACK;
		s4 = RGB_BLACK;
		case (pal)
			PAL_BYR: begin
				s0 = RGB_BLUE; s1 = RGB_YELLOW; s2 = RGB_RED;
			end
			PAL_BRY: begin
				s0 = RGB_BLUE; s1 = RGB_RED; s2 = RGB_YELLOW;
			end
			PAL_BGYR: begin
				s0 = RGB_BLUE; s1 = RGB_GREEN; s2 = RGB_YELLOW; s3 = RGB_RED;
			end
			PAL_WHITE_HOT: begin
				s0 = RGB_BLACK; s1 = RGB_WHITE;
			end
			PAL_BLACK_HOT: begin
				s0 = RGB_WHITE; s1 = RGB_BLACK;
			end
			PAL_BK_BYRW: begin
				s0 = RGB_BLACK; s1 = RGB_BLUE; s2 = RGB_YELLOW; s3 = RGB_RED;
				s4 = RGB_WHITE;
			end
			PAL_BK_BRYW: begin
				s0 = RGB_BLACK; s1 = RGB_BLUE; s2 = RGB_RED; s3 = RGB_YELLOW;
				s4 = RGB_WHITE;
			end
			default: begin
				s0 = RGB_BLACK;
			end
		endcase
		case (q)
			3'd0:    c = s0;
			3'd1:    c = s1;
			3'd2:    c = s2;
			3'd3:    c = s3;
			3'd4:    c = s4;
			default: c = RGB_BLACK;
		endcase
		return c;
	endfunction

endpackage

@@ hw/rtl/tpcm_if.sv @@
interface pixel_if;
	import tpcm_pkg::*;

	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] level;

	modport source (output valid, output level, input ready);
	modport sink (input valid, input level, output ready);
endinterface

interface color_if;
	import tpcm_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

@@ hw/rtl/thermal_palette_color_map.sv @@
// Thermal palette color map. Each pixel item carries a level, and each result item
// carries the 8-bit red, green and blue of that level under the palette chosen by
// cfg_wdata (written when cfg_we is high; codes above six act as the first palette).
// One item is taken per clock while no stall holds pixel.ready low, and its color leaves
// through the stop-table read register, the blend stage and the output register; each
// item needs a single read of the stop table and one reciprocal-multiply stage that does
// the exact rounding. After reset all 56 entries load from constants with pixel.ready low;
// the palette register can be written at any time while no item is in flight.
module thermal_palette_color_map (
	input  logic                       clk,
	input  logic                       arst_n,
	pixel_if.sink                      pixel,
	color_if.source                    color,
	input  logic                       cfg_we,
	input  logic [tpcm_pkg::PAL_W-1:0] cfg_wdata
);
	import tpcm_pkg::*;

	logic [PAL_W-1:0] palette_select_q;
	palette_t         pal_eff;
	logic [SEG_W-1:0] segs;
	logic [POS_W-1:0] pos;
	logic [CMP_W-1:0] pos_c;
	logic [CMP_W-1:0] base;
	logic [CMP_W-1:0] k_full;
	logic [Q_W-1:0]   q_n;
	logic [K_W-1:0]   k_n;
	logic             tbl_ready;
	logic             accept;
	logic             en_s1;
	logic             take_s1;
	logic             v_s1;
	logic [K_W-1:0]   k_s1;
	stop_pair_t       pair_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_select_q <= '0;
		end else if (cfg_we) begin
			palette_select_q <= cfg_wdata;
		end
	end

	// Segment index and remainder of level*(stops-1) over LEVELS, by compares.
	always_comb begin
		pal_eff = (palette_select_q >= PAL_W'(NUM_PAL)) ? PAL_BYR : palette_t'(palette_select_q);
		segs    = seg_count(pal_eff);
		pos     = POS_W'(pixel.level) * POS_W'(segs);
		pos_c   = CMP_W'(pos);
		q_n     = '0;
		base    = '0;
		for (int j = 1; j < 4; j++) begin
			if (pos_c >= CMP_W'(j * LEVELS)) begin
				q_n  = Q_W'(j);
				base = CMP_W'(j * LEVELS);
			end
		end
		k_full = pos_c - base;
		k_n    = K_W'(k_full);
		// A level beyond the range lands on the last stop.
		if (CMP_W'(pixel.level) >= CMP_W'(LEVELS)) begin
			q_n = Q_W'(segs);
			k_n = '0;
		end
	end

	assign en_s1       = !v_s1 || take_s1;
	assign pixel.ready = tbl_ready && en_s1;
	assign accept      = pixel.valid && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			k_s1 <= k_n;
		end
	end

	tpcm_stop_table u_stop_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_pal  (pal_eff),
		.rd_q    (q_n),
		.rd_data (pair_s1),
		.ready   (tbl_ready)
	);

	tpcm_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.k        (k_s1),
		.pair     (pair_s1),
		.take     (take_s1),
		.color    (color)
	);

`ifndef NO_ASSERTIONS
	a_accept_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.ready |=> v_s1)
		else $error("accepted item did not reach the first stage");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !take_s1 |=> v_s1 && $stable(k_s1) && $stable(pair_s1))
		else $error("stalled first stage lost its item");
`endif

endmodule

@@ hw/rtl/tpcm_ram.sv @@
module tpcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/tpcm_stop_table.sv @@
module tpcm_stop_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  tpcm_pkg::palette_t          rd_pal,
	input  logic [tpcm_pkg::Q_W-1:0]    rd_q,
	output tpcm_pkg::stop_pair_t        rd_data,
	output logic                        ready
);
	import tpcm_pkg::*;

	logic [FILL_W-1:0]  fill_q;
	logic               filling;
	logic [TADDR_W-1:0] waddr;
	palette_t           fill_pal;
	logic [Q_W-1:0]     fill_seg;
	stop_pair_t         fill_pair;
	logic [$bits(stop_pair_t)-1:0] rd_raw;

	assign filling  = fill_q != FILL_W'(TABLE_DEPTH);
	assign ready    = !filling;
	assign waddr    = fill_q[TADDR_W-1:0];
	assign fill_pal = palette_t'(waddr[TADDR_W-1:Q_W]);
	assign fill_seg = waddr[Q_W-1:0];

	// Each entry holds the stop of its segment and the stop it blends toward;
	// the last stop of a palette blends toward itself.
	always_comb begin
		fill_pair.lo = stop_rgb(fill_pal, fill_seg);
		if (fill_seg < seg_count(fill_pal)) begin
			fill_pair.hi = stop_rgb(fill_pal, fill_seg + Q_W'(1));
		end else begin
			fill_pair.hi = fill_pair.lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (filling) begin
			fill_q <= fill_q + FILL_W'(1);
		end
	end

	tpcm_ram #(
		.WIDTH ($bits(stop_pair_t)),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (filling),
		.waddr (waddr),
		.wdata (fill_pair),
		.re    (rd_en),
		.raddr ({rd_pal, rd_q}),
		.rdata (rd_raw)
	);

	assign rd_data = stop_pair_t'(rd_raw);

`ifndef NO_ASSERTIONS
	a_read_after_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !filling)
		else $error("stop table read during fill");

	a_fill_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		!filling |=> !filling)
		else $error("stop table fill restarted");
`endif

endmodule

@@ hw/rtl/tpcm_blend.sv @@
module tpcm_blend (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [tpcm_pkg::K_W-1:0] k,
	input  tpcm_pkg::stop_pair_t     pair,
	output logic                     take,
	color_if.source                  color
);
	import tpcm_pkg::*;

	logic            en_out;
	logic            en_s2;
	logic            v_s2;
	rgb_t            lo_s2;
	rgb_t            hi_s2;
	logic [CH_W-1:0] up_s2;
	logic [CH_W-1:0] dn_s2;
	rgb_t            hi_eff;
	logic [CH_W-1:0] up_n;
	logic [CH_W-1:0] dn_n;
	logic            valid_q;
	logic [CH_W-1:0] red_q;
	logic [CH_W-1:0] green_q;
	logic [CH_W-1:0] blue_q;

	// Rounded 255*m/LEVELS, computed as an exact reciprocal multiply.
	function automatic logic [CH_W-1:0] scale_frac(input logic [M_W-1:0] m);
		logic [X_W-1:0]    x;
		logic [PROD_W-1:0] p;
		x = X_W'(m) * X_W'(FULL_SCALE) + X_W'(LEVELS / 2);
		p = PROD_W'(x) * PROD_W'(RECIP);
		return CH_W'(p >> DIV_SH);
	endfunction

	function automatic logic [CH_W-1:0] channel(input logic lo, input logic hi,
		input logic [CH_W-1:0] up, input logic [CH_W-1:0] dn);
		logic [CH_W-1:0] c;
		if (lo == hi) begin
			c = lo ? CH_W'(FULL_SCALE) : '0;
		end else if (hi) begin
			c = up;
		end else begin
			c = dn;
		end
		return c;
	endfunction

	assign en_out = !valid_q || color.ready;
	assign en_s2  = !v_s2 || en_out;
	assign take   = en_s2;

	// With no fraction left the color is the lower stop itself.
	assign hi_eff = (k == '0) ? pair.lo : pair.hi;
	assign up_n   = scale_frac(M_W'(k));
	assign dn_n   = scale_frac(M_W'(LEVELS) - M_W'(k));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (en_s2) begin
				v_s2 <= in_valid;
			end
			if (en_out) begin
				valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && in_valid) begin
			lo_s2 <= pair.lo;
			hi_s2 <= hi_eff;
			up_s2 <= up_n;
			dn_s2 <= dn_n;
		end
		if (en_out && v_s2) begin
			red_q   <= channel(lo_s2[2], hi_s2[2], up_s2, dn_s2);
			green_q <= channel(lo_s2[1], hi_s2[1], up_s2, dn_s2);
			blue_q  <= channel(lo_s2[0], hi_s2[0], up_s2, dn_s2);
		end
	end

	assign color.valid = valid_q;
	assign color.red   = red_q;
	assign color.green = green_q;
	assign color.blue  = blue_q;

`ifndef NO_ASSERTIONS
	a_out_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(color.valid) |-> $past(v_s2))
		else $error("result appeared without a blended item behind it");
`endif

endmodule

@@ tb/sv/thermal_palette_color_map_tb.sv @@
`timescale 1ns / 1ps

module thermal_palette_color_map_tb;
	import tpcm_pkg::*;

	// Code 7 has no palette of its own and must behave as the first palette.
	localparam logic [PAL_W-1:0] PAL_UNUSED = 3'd7;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 175;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_color_t;

	// Color stops per palette, stop j at bits [3*j +: 3].
	localparam logic [14:0] GRADIENT [0:6] = '{
		{RGB_BLACK, RGB_BLACK, RGB_RED, RGB_YELLOW, RGB_BLUE},
		{RGB_BLACK, RGB_BLACK, RGB_YELLOW, RGB_RED, RGB_BLUE},
		{RGB_BLACK, RGB_RED, RGB_YELLOW, RGB_GREEN, RGB_BLUE},
		{RGB_BLACK, RGB_BLACK, RGB_BLACK, RGB_WHITE, RGB_BLACK},
		{RGB_BLACK, RGB_BLACK, RGB_BLACK, RGB_BLACK, RGB_WHITE},
		{RGB_WHITE, RGB_RED, RGB_YELLOW, RGB_BLUE, RGB_BLACK},
		{RGB_WHITE, RGB_YELLOW, RGB_RED, RGB_BLUE, RGB_BLACK}
	};
	localparam int STOP_COUNT [0:6] = '{3, 3, 4, 2, 2, 5, 5};

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [PAL_W-1:0]    cfg_wdata;

	pixel_if pix ();
	color_if col ();

	logic [LEVEL_W-1:0]  level_q [$];
	pixel_color_t        color_q [$];
	logic [PAL_W-1:0]    cur_palette;
	bit                  idling;
	int                  gap_left;
	int                  stall_left;
	int                  mismatches;

	thermal_palette_color_map u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pix),
		.color     (col),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	function automatic int palette_index(input logic [PAL_W-1:0] sel);
		return (sel > PAL_BK_BRYW) ? int'(PAL_BYR) : int'(sel);
	endfunction

	function automatic pixel_color_t predict_color(input logic [PAL_W-1:0] sel,
			input logic [LEVEL_W-1:0] lvl);
		int           pal;
		int unsigned  pos;
		int unsigned  seg;
		int unsigned  frac;
		int unsigned  ramp;
		rgb_t         from_c;
		rgb_t         to_c;
		logic [CH_W-1:0] chan [0:2];
		pal = palette_index(sel);
		pos = lvl * (STOP_COUNT[pal] - 1);
		seg = pos / LEVELS;
		frac = pos % LEVELS;
		from_c = GRADIENT[pal][3*seg +: 3];
		to_c = (frac == 0) ? from_c : GRADIENT[pal][3*(seg+1) +: 3];
		// Index 0 is red, matching bit 2 of a stop color.
		for (int i = 0; i < 3; i++) begin
			if (from_c[2-i] == to_c[2-i]) begin
				chan[i] = from_c[2-i] ? CH_W'(FULL_SCALE) : '0;
			end else begin
				ramp = to_c[2-i] ? frac : LEVELS - frac;
				chan[i] = CH_W'((FULL_SCALE * ramp + LEVELS / 2) / LEVELS);
			end
		end
		return '{red: chan[0], green: chan[1], blue: chan[2]};
	endfunction

	task automatic check_channel(input string name, input logic [CH_W-1:0] expd,
			input logic [CH_W-1:0] got);
		if (got !== expd) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expd, got);
			mismatches++;
		end
	endtask

	// Pixel driver: presents the next pending level, with random gaps between items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix.valid <= 1'b0;
			pix.level <= '0;
			gap_left = 0;
		end else if (!pix.valid || pix.ready) begin
			if (gap_left > 0) begin
				gap_left--;
				pix.valid <= 1'b0;
			end else if (level_q.size() > 0) begin
				pix.valid <= 1'b1;
				pix.level <= level_q.pop_front();
				if (idling && $urandom_range(0, 7) == 0)
					gap_left = $urandom_range(1, 12);
			end else begin
				pix.valid <= 1'b0;
			end
		end
	end

	// Color monitor: checks each result item, then records the expectation for a newly
	// accepted pixel item, and stalls ready in random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (col.valid && col.ready) begin
				if (color_q.size() == 0) begin
					$display("%0t: unexpected color item, expected none, actual %0d/%0d/%0d",
						$time, col.red, col.green, col.blue);
					mismatches++;
				end else begin
					pixel_color_t expd;
					expd = color_q.pop_front();
					check_channel("red", expd.red, col.red);
					check_channel("green", expd.green, col.green);
					check_channel("blue", expd.blue, col.blue);
				end
			end
			if (pix.valid && pix.ready)
				color_q.push_back(predict_color(cur_palette, pix.level));
			if (stall_left > 0) begin
				stall_left--;
				col.ready <= 1'b0;
			end else begin
				col.ready <= 1'b1;
				if (idling && $urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 12);
			end
		end
	end

	task automatic wait_idle();
		while (level_q.size() != 0 || pix.valid || color_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// The palette is only changed with no item in flight.
	task automatic set_palette(input logic [PAL_W-1:0] code);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= code;
		cur_palette = code;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [PAL_W-1:0] phase_pal [0:RANDOM_PHASES-1];
		int               segs;
		int               lvl;
		phase_pal = '{PAL_UNUSED, PAL_BYR, PAL_BRY, PAL_BGYR, PAL_WHITE_HOT,
			PAL_BLACK_HOT, PAL_BK_BYRW, PAL_BK_BRYW, PAL_UNUSED, PAL_BYR};
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		pix.valid = 1'b0;
		pix.level = '0;
		col.ready = 1'b0;
		cur_palette = PAL_BYR;
		idling = 1'b1;
		mismatches = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Every palette code at the lowest level, the middle and the top.
		for (int p = 0; p < 8; p++) begin
			set_palette(PAL_W'(p));
			level_q.push_back(8'd0);
			level_q.push_back(8'd128);
			level_q.push_back(8'd255);
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_palette(phase_pal[ph]);
			if (ph == RANDOM_PHASES - 1)
				idling = 1'b0;
			segs = STOP_COUNT[palette_index(phase_pal[ph])] - 1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				case ($urandom_range(0, 9))
					0: lvl = $urandom_range(0, 1) ? 255 - $urandom_range(0, 2)
						: $urandom_range(0, 2);
					1, 2: begin
						// Straddle a segment boundary of the current palette.
						lvl = (LEVELS * $urandom_range(1, segs) + segs - 1) / segs
							+ $urandom_range(0, 2) - 1;
						if (lvl > 255)
							lvl = 255;
					end
					default: lvl = $urandom_range(0, 255);
				endcase
				level_q.push_back(LEVEL_W'(lvl));
			end
		end

		wait_idle();
		if (mismatches == 0 && color_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
